>>> rtl/min_heap_priority_queue_assert.svh
// Assertion macros for the min-heap priority queue checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mhpq_pkg.sv
// Shared types and constants of the min-heap priority queue.
// No dependencies; every other file but the assertion macros header imports it.
package mhpq_pkg;

    localparam int MHPQ_CAPACITY = 1024;
    localparam int MHPQ_CNT_W    = $clog2(MHPQ_CAPACITY + 1);
    localparam int KEY_W         = 16;
    localparam int COST_W        = 24;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_RELAX = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              side;
        logic [COST_W-1:0] cost;
    } t_entry;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PUSH,
        S_SU_START,
        S_SU,
        S_FIN,
        S_POP_RD,
        S_POP_LD,
        S_SD_ISSUE,
        S_SD_STEP,
        S_SCAN,
        S_RD0,
        S_REPORT
    } t_state;

    // One datapath operation per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH_INIT,
        OP_SU_ISSUE,
        OP_SU_STEP,
        OP_WRITE_CUR,
        OP_POP_ISSUE,
        OP_POP_LOAD,
        OP_SD_ISSUE,
        OP_SD_STEP,
        OP_SCAN_INIT,
        OP_SCAN_STEP,
        OP_RD0,
        OP_REPORT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status stat;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    full;
        logic    empty;
        logic    pos_zero;
        logic    up_move;
        logic    par_zero;
        logic    down_end;
        logic    down_stop;
        logic    found;
        logic    scan_end;
        logic    out_free;
    } t_dp_stat;

endpackage

>>> rtl/mhpq_if.sv
// Request and response channel interfaces of the min-heap priority queue.
// Depends on mhpq_pkg for field widths.
interface mhpq_req_if import mhpq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [KEY_W-1:0]  item_key;
    logic              from_side;
    logic [COST_W-1:0] cost;

    modport source (output valid, action, item_key, from_side, cost, input ready);
    modport sink   (input valid, action, item_key, from_side, cost, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; #(
    parameter int CNT_W = MHPQ_CNT_W
) ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic              entry_valid;
    logic [KEY_W-1:0]  entry_key;
    logic              entry_side;
    logic [COST_W-1:0] entry_cost;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, status, entry_valid, entry_key, entry_side, entry_cost,
                    entry_count, input ready);
    modport sink   (input valid, status, entry_valid, entry_key, entry_side, entry_cost,
                    entry_count, output ready);
endinterface

>>> rtl/mhpq_ctrl.sv
// Controller of the min-heap priority queue: sequences push, pop, relax and report.
// Depends on mhpq_pkg; drives the datapath through t_cmd and reads t_dp_stat.
module mhpq_ctrl import mhpq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd
);

    t_state  r_state, n_state;
    t_status r_status, n_status;

    // State and pending status register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= STAT_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // Next state and command
    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        o_cmd.op    = OP_NONE;
        o_cmd.stat  = r_status;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_status = STAT_OK;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.act)
                    ACT_PUSH: begin
                        if (i_stat.full) begin
                            n_status = STAT_FULL;
                            n_state  = S_RD0;
                        end else begin
                            n_state = S_PUSH;
                        end
                    end
                    ACT_POP: begin
                        if (i_stat.empty) begin
                            n_status = STAT_EMPTY;
                            n_state  = S_RD0;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end
                    ACT_RELAX: begin
                        o_cmd.op = OP_SCAN_INIT;
                        n_state  = S_SCAN;
                    end
                    default: n_state = S_RD0;
                endcase
            end
            S_PUSH: begin
                o_cmd.op = OP_PUSH_INIT;
                n_state  = S_SU_START;
            end
            S_SU_START: begin
                if (i_stat.pos_zero) begin
                    o_cmd.op = OP_WRITE_CUR;
                    n_state  = S_RD0;
                end else begin
                    o_cmd.op = OP_SU_ISSUE;
                    n_state  = S_SU;
                end
            end
            S_SU: begin
                o_cmd.op = OP_SU_STEP;
                priority if (!i_stat.up_move) n_state = S_RD0;
                else if (i_stat.par_zero)     n_state = S_FIN;
                else                          n_state = S_SU;
            end
            S_FIN: begin
                o_cmd.op = OP_WRITE_CUR;
                n_state  = S_RD0;
            end
            S_POP_RD: begin
                o_cmd.op = OP_POP_ISSUE;
                n_state  = S_POP_LD;
            end
            S_POP_LD: begin
                o_cmd.op = OP_POP_LOAD;
                n_state  = S_SD_ISSUE;
            end
            S_SD_ISSUE: begin
                if (i_stat.down_end) begin
                    o_cmd.op = OP_WRITE_CUR;
                    n_state  = S_RD0;
                end else begin
                    o_cmd.op = OP_SD_ISSUE;
                    n_state  = S_SD_STEP;
                end
            end
            S_SD_STEP: begin
                o_cmd.op = OP_SD_STEP;
                n_state  = i_stat.down_stop ? S_RD0 : S_SD_ISSUE;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN_STEP;
                priority if (i_stat.found) begin
                    n_state = S_SU_START;
                end else if (i_stat.scan_end) begin
                    if (i_stat.full) begin
                        n_status = STAT_FULL;
                        n_state  = S_RD0;
                    end else begin
                        n_state = S_PUSH;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_RD0: begin
                o_cmd.op = OP_RD0;
                n_state  = S_REPORT;
            end
            S_REPORT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_REPORT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> rtl/mhpq_dp.sv
// Datapath of the min-heap priority queue: heap memory, sift registers, scan and output.
// Depends on mhpq_pkg and mhpq_rsp_if; executes one t_cmd operation per cycle.
module mhpq_dp import mhpq_pkg::*; #(
    parameter int CAPACITY = MHPQ_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_entry      i_load_entry,
    input  t_action     i_load_act,
    output t_dp_stat    o_stat,
    mhpq_rsp_if.source  o_rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SW    = CNT_W + 1;
    localparam int DW    = IDX_W + 2;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Heap memory, one write port and two registered read ports
    t_entry mem [CAPACITY];

    t_entry           r_rd_a, r_rd_b;
    t_entry           r_cur, r_res;
    t_action          r_act;
    logic             r_popped;
    logic [IDX_W-1:0] r_pos, r_par;
    logic [CNT_W-1:0] r_count;
    logic [SW-1:0]    r_scan, r_chk;
    logic             r_pend;

    logic             r_ovalid;
    t_status          r_o_status;
    logic             r_o_evalid;
    t_entry           r_o_entry;
    logic [CNT_W-1:0] r_o_count;

    logic             we;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             re_a, re_b;
    logic [IDX_W-1:0] rd_addr_a, rd_addr_b;

    logic [IDX_W-1:0] pos_parent, par_parent;
    logic [DW-1:0]    c1, c2;
    logic             c2_ok, take_b;
    t_entry           child;
    logic [IDX_W-1:0] child_idx;
    logic [SW-1:0]    count_ext;
    logic             match_a, match_b;
    logic [IDX_W-1:0] found_idx;
    logic             out_free;
    logic             up_move, down_stop;

    // Neighbor addresses
    assign pos_parent = (r_pos - IDX_W'(1)) >> 1;
    assign par_parent = (r_par - IDX_W'(1)) >> 1;
    assign c1         = {1'b0, r_pos, 1'b1};
    assign c2         = c1 + DW'(1);
    assign c2_ok      = c2 < DW'(r_count);
    assign take_b     = c2_ok && (r_rd_a.cost >= r_rd_b.cost);
    assign child      = take_b ? r_rd_b : r_rd_a;
    assign child_idx  = take_b ? c2[IDX_W-1:0] : c1[IDX_W-1:0];
    assign up_move    = r_cur.cost < r_rd_a.cost;
    assign down_stop  = r_cur.cost <= child.cost;

    // Scan match on the pair read last cycle
    assign count_ext  = {1'b0, r_count};
    assign match_a    = r_pend && (r_chk < count_ext) && (r_rd_a.key == r_cur.key);
    assign match_b    = r_pend && ((r_chk + SW'(1)) < count_ext) && (r_rd_b.key == r_cur.key);
    assign found_idx  = match_a ? r_chk[IDX_W-1:0] : IDX_W'(r_chk + SW'(1));
    assign out_free   = !r_ovalid || o_rsp.ready;

    // Status to the controller
    always_comb begin
        o_stat.act       = r_act;
        o_stat.full      = r_count == CAP_CNT;
        o_stat.empty     = r_count == '0;
        o_stat.pos_zero  = r_pos == '0;
        o_stat.up_move   = up_move;
        o_stat.par_zero  = r_par == '0;
        o_stat.down_end  = c1 >= DW'(r_count);
        o_stat.down_stop = down_stop;
        o_stat.found     = match_a || match_b;
        o_stat.scan_end  = r_pend && !(match_a || match_b) && ((r_chk + SW'(2)) >= count_ext);
        o_stat.out_free  = out_free;
    end

    // Memory port selection
    always_comb begin
        we        = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_cur;
        re_a      = 1'b0;
        re_b      = 1'b0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        unique case (i_cmd.op)
            OP_WRITE_CUR: we = 1'b1;
            OP_SU_ISSUE: begin
                re_a      = 1'b1;
                rd_addr_a = pos_parent;
            end
            OP_SU_STEP: begin
                we        = 1'b1;
                wr_data   = up_move ? r_rd_a : r_cur;
                re_a      = 1'b1;
                rd_addr_a = par_parent;
            end
            OP_POP_ISSUE: begin
                re_a      = 1'b1;
                re_b      = 1'b1;
                rd_addr_b = IDX_W'(r_count - CNT_W'(1));
            end
            OP_SD_ISSUE: begin
                re_a      = 1'b1;
                re_b      = 1'b1;
                rd_addr_a = c1[IDX_W-1:0];
                rd_addr_b = c2[IDX_W-1:0];
            end
            OP_SD_STEP: begin
                we      = 1'b1;
                wr_data = down_stop ? r_cur : child;
            end
            OP_SCAN_STEP: begin
                re_a      = 1'b1;
                re_b      = 1'b1;
                rd_addr_a = r_scan[IDX_W-1:0];
                rd_addr_b = IDX_W'(r_scan + SW'(1));
            end
            OP_RD0: re_a = 1'b1;
            default: ;
        endcase
    end

    // Memory write and registered reads
    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        if (re_a) r_rd_a <= mem[rd_addr_a];
        if (re_b) r_rd_b <= mem[rd_addr_b];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_PUSH_INIT: r_count <= r_count + CNT_W'(1);
                OP_POP_LOAD:  r_count <= r_count - CNT_W'(1);
                OP_SCAN_INIT: r_pend  <= 1'b0;
                OP_SCAN_STEP: r_pend  <= 1'b1;
                default: ;
            endcase
            if (i_cmd.op == OP_REPORT) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_cur    <= i_load_entry;
                r_act    <= i_load_act;
                r_popped <= 1'b0;
            end
            OP_PUSH_INIT: r_pos <= r_count[IDX_W-1:0];
            OP_SU_ISSUE:  r_par <= pos_parent;
            OP_SU_STEP: begin
                if (up_move) begin
                    r_pos <= r_par;
                    r_par <= par_parent;
                end
            end
            OP_POP_LOAD: begin
                r_res    <= r_rd_a;
                r_cur    <= r_rd_b;
                r_popped <= 1'b1;
                r_pos    <= '0;
            end
            OP_SD_STEP: begin
                if (!down_stop) r_pos <= child_idx;
            end
            OP_SCAN_INIT: r_scan <= '0;
            OP_SCAN_STEP: begin
                r_chk  <= r_scan;
                r_scan <= r_scan + SW'(2);
                if (match_a || match_b) r_pos <= found_idx;
            end
            OP_REPORT: begin
                r_o_status <= i_cmd.stat;
                r_o_count  <= r_count;
                r_o_evalid <= r_popped || (r_count != '0);
                if (r_popped) begin
                    r_o_entry <= r_res;
                end else if (r_count != '0) begin
                    r_o_entry <= r_rd_a;
                end else begin
                    r_o_entry <= '0;
                end
            end
            default: ;
        endcase
    end

    // Drive the response channel
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.entry_valid = r_o_evalid;
    assign o_rsp.entry_key   = r_o_entry.key;
    assign o_rsp.entry_side  = r_o_entry.side;
    assign o_rsp.entry_cost  = r_o_entry.cost;
    assign o_rsp.entry_count = r_o_count;

endmodule

>>> rtl/min_heap_priority_queue.sv
// Binary min-heap priority queue of CAPACITY entries (16-bit key, side bit, 24-bit cost),
// one item at a time, one response item per request item. A push sifts up, and the sift-up
// reads one ancestor per cycle from the heap memory; a pop sifts down, and each sift-down
// level reads both children on the memory's two read ports and then compares; relax
// scans two stored entries per cycle on those same ports up to the end of the scan, then
// pushes the item or sifts up a found entry. A request item is taken while the previous
// response item still waits in the output register. No clearing pass after reset.
// Depends on mhpq_pkg, mhpq_if, mhpq_ctrl and mhpq_dp.
module min_heap_priority_queue import mhpq_pkg::*; #(
    parameter int CAPACITY = MHPQ_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);

    t_cmd     cmd;
    t_dp_stat dp_stat;
    t_entry   load_entry;
    logic     in_ready;

    // Pack the request payload
    assign load_entry.key  = i_req.item_key;
    assign load_entry.side = i_req.from_side;
    assign load_entry.cost = i_req.cost;
    assign i_req.ready     = in_ready;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (cmd)
    );

    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_load_entry (load_entry),
        .i_load_act   (t_action'(i_req.action)),
        .o_stat       (dp_stat),
        .o_rsp        (o_rsp)
    );

endmodule

>>> rtl/mhpq_chk.sv
// Port-level checker of the min-heap priority queue response channel, bound to the top.
// Depends on mhpq_pkg and the assertion macros header.
`include "min_heap_priority_queue_assert.svh"

module mhpq_chk import mhpq_pkg::*; #(
    parameter int CAPACITY = MHPQ_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic [1:0]        i_status,
    input logic              i_entry_valid,
    input logic [KEY_W-1:0]  i_entry_key,
    input logic              i_entry_side,
    input logic [COST_W-1:0] i_entry_cost,
    input logic [CNT_W-1:0]  i_entry_count
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam int PW = 4 + KEY_W + COST_W + CNT_W;

    logic          rsp_stall;
    logic [PW-1:0] rsp_payload;
    logic          rsp_full, rsp_empty, rsp_none;
    logic          heap_full, heap_empty, fields_zero;

    // Conditions seen on the response channel
    assign rsp_stall   = i_valid && !i_ready;
    assign rsp_payload = {i_status, i_entry_valid, i_entry_key, i_entry_side, i_entry_cost,
                          i_entry_count};
    assign rsp_full    = i_valid && (i_status == STAT_FULL);
    assign rsp_empty   = i_valid && (i_status == STAT_EMPTY);
    assign rsp_none    = i_valid && !i_entry_valid;
    assign heap_full   = i_entry_count == CAP_CNT;
    assign heap_empty  = i_entry_count == '0;
    assign fields_zero = (i_entry_key == '0) && !i_entry_side && (i_entry_cost == '0);

    // Hold a stalled response item
    `MHPQ_ASSERT_NEXT(a_rsp_hold, rsp_stall, i_valid && $stable(rsp_payload), "stalled item changed")

    // Count never exceeds the capacity
    `MHPQ_ASSERT(a_count_max, i_valid, i_entry_count <= CAP_CNT, "entry count above capacity")

    // Dropped item only on a full heap
    `MHPQ_ASSERT(a_full_count, rsp_full, heap_full && i_entry_valid, "full status, heap not full")

    // Empty pop reports nothing and an empty heap
    `MHPQ_ASSERT(a_empty_pop, rsp_empty, heap_empty && !i_entry_valid, "empty status, entries held")

    // No reported entry means zeroed fields and an empty heap
    `MHPQ_ASSERT(a_no_entry, rsp_none, heap_empty && fields_zero, "invalid entry, nonzero fields")

endmodule

bind min_heap_priority_queue mhpq_chk #(
    .CAPACITY (CAPACITY)
) u_mhpq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_rsp.valid),
    .i_ready       (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_entry_valid (o_rsp.entry_valid),
    .i_entry_key   (o_rsp.entry_key),
    .i_entry_side  (o_rsp.entry_side),
    .i_entry_cost  (o_rsp.entry_cost),
    .i_entry_count (o_rsp.entry_count)
);
